@@ rtl/grid_percolation_quick_find_assert.svh @@
// Assertion macros used by the checker of the percolation engine.
`ifndef GRID_PERCOLATION_QUICK_FIND_ASSERT_SVH
`define GRID_PERCOLATION_QUICK_FIND_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define GPQ_ASSERT_NOW(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("percolation engine assertion failed");

// Check a consequence in the cycle after its trigger.
`define GPQ_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("percolation engine assertion failed");

`endif

@@ rtl/gpq_pkg.sv @@
package gpq_pkg;

   // Width of the row and column fields of an item.
   localparam int COORD_W = 5;

   // Default side length of the square grid.
   localparam int GRID_SIDE_DEF = 32;

   // Neighbor visiting order: up, down, left, right.
   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } gpq_dir_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        clear;      // write one reset entry, advance clear address
      logic        load;       // capture an accepted item
      logic        rd_here;    // read the opened site
      logic        open_here;  // read data valid for opened site: mark it open
      logic        rd_nbr;     // read the neighbor in direction dir
      logic        nbr_check;  // read data valid for neighbor: start merge if open
      logic        give;       // load the result register
      gpq_dir_type dir;
   } gpq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic in_range;
      logic nbr_exists;
      logic nbr_open;
      logic walk_done;
      logic out_free;
   } gpq_status_type;

endpackage

@@ rtl/gpq_ram.sv @@
module gpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gpq_controller.sv @@
module gpq_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gpq_pkg::gpq_status_type status,
   output gpq_pkg::gpq_cmd_type    cmd
);

   import gpq_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR     = 8'b0000_0001,
      S_IDLE      = 8'b0000_0010,
      S_READ_HERE = 8'b0000_0100,
      S_OPEN_HERE = 8'b0000_1000,
      S_NBR_SEL   = 8'b0001_0000,
      S_NBR_CHECK = 8'b0010_0000,
      S_WALK      = 8'b0100_0000,
      S_DONE      = 8'b1000_0000
   } gpq_state_type;

   gpq_state_type state_ff, state_in;
   gpq_dir_type   dir_ff, dir_in;
   gpq_dir_type   dir_next;
   logic          dir_last;

   // Step to the next neighbor direction.
   always_comb begin
      case (dir_ff)
         DIR_UP:   dir_next = DIR_DOWN;
         DIR_DOWN: dir_next = DIR_LEFT;
         DIR_LEFT: dir_next = DIR_RIGHT;
         default:  dir_next = DIR_UP;
      endcase
   end

   assign dir_last = (dir_ff == DIR_RIGHT);

   // Sequence one item: open the site, then merge with each open neighbor.
   always_comb begin
      state_in  = state_ff;
      dir_in    = dir_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.dir   = dir_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ_HERE;
            end
         end
         S_READ_HERE: begin
            if (!status.in_range) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_here = 1'b1;
               state_in    = S_OPEN_HERE;
            end
         end
         S_OPEN_HERE: begin
            cmd.open_here = 1'b1;
            dir_in        = DIR_UP;
            state_in      = S_NBR_SEL;
         end
         S_NBR_SEL: begin
            if (status.nbr_exists) begin
               cmd.rd_nbr = 1'b1;
               state_in   = S_NBR_CHECK;
            end else if (dir_last) begin
               state_in = S_DONE;
            end else begin
               dir_in = dir_next;
            end
         end
         S_NBR_CHECK: begin
            cmd.nbr_check = 1'b1;
            if (status.nbr_open) begin
               state_in = S_WALK;
            end else if (dir_last) begin
               state_in = S_DONE;
            end else begin
               dir_in   = dir_next;
               state_in = S_NBR_SEL;
            end
         end
         S_WALK: begin
            if (status.walk_done) begin
               if (dir_last) begin
                  state_in = S_DONE;
               end else begin
                  dir_in   = dir_next;
                  state_in = S_NBR_SEL;
               end
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.give = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         dir_ff   <= DIR_UP;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

@@ rtl/gpq_datapath.sv @@
module gpq_datapath #(
   parameter int GRID_SIDE = gpq_pkg::GRID_SIDE_DEF,
   localparam int IDX_W = $clog2(GRID_SIDE * GRID_SIDE),
   localparam int WORD_W = IDX_W + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gpq_pkg::gpq_cmd_type         cmd,
   output gpq_pkg::gpq_status_type      status,
   input  logic [gpq_pkg::COORD_W-1:0]  req_row,
   input  logic [gpq_pkg::COORD_W-1:0]  req_column,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_percolates,
   output logic                         rsp_site_full,
   output logic                         ram_wr_en,
   output logic [IDX_W-1:0]             ram_wr_addr,
   output logic [WORD_W-1:0]            ram_wr_data,
   output logic [IDX_W-1:0]             ram_rd_addr,
   input  logic [WORD_W-1:0]            ram_rd_data
);

   import gpq_pkg::*;

   localparam int SITE_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int LAST_SITE  = SITE_COUNT - 1;
   localparam int BOTTOM_BASE = (GRID_SIDE - 1) * GRID_SIDE;
   localparam int SIDE_W = $clog2(GRID_SIDE + 1);
   localparam int CMP_W  = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;
   localparam int PROD_W = CMP_W + SIDE_W;

   // Memory word: open flag, full flag, component label.
   localparam int OPEN_BIT = WORD_W - 1;
   localparam int FULL_BIT = WORD_W - 2;

   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic               in_range_ff, in_range_in;
   logic [IDX_W-1:0]   here_ff, here_in;
   logic [IDX_W-1:0]   new_lab_ff, new_lab_in;
   logic [IDX_W-1:0]   old_lab_ff, old_lab_in;
   logic               here_full_ff, here_full_in;
   logic               wet_ff, wet_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]   wk_rd_ff, wk_rd_in;
   logic [IDX_W-1:0]   wk_wr_ff, wk_wr_in;
   logic               wk_run_ff, wk_run_in;
   logic               wk_pend_ff, wk_pend_in;
   logic               perc_ff, perc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_perc_ff, rsp_perc_in;
   logic               rsp_full_ff, rsp_full_in;

   logic [PROD_W-1:0]  here_wide;
   logic [CMP_W-1:0]   row_c, col_c;
   logic               req_in_range;
   logic               rd_open, rd_full;
   logic [IDX_W-1:0]   rd_label;
   logic               nbr_exists;
   logic [IDX_W-1:0]   nbr_addr;
   logic               wk_match;

   // Site index and range check of the incoming item.
   assign here_wide = PROD_W'(req_row) * PROD_W'(GRID_SIDE) + PROD_W'(req_column);
   assign req_in_range = (CMP_W'(req_row) < CMP_W'(GRID_SIDE)) &&
                         (CMP_W'(req_column) < CMP_W'(GRID_SIDE));

   assign rd_open  = ram_rd_data[OPEN_BIT];
   assign rd_full  = ram_rd_data[FULL_BIT];
   assign rd_label = ram_rd_data[IDX_W-1:0];

   // Neighbor address and existence for the current direction.
   assign row_c = CMP_W'(row_ff);
   assign col_c = CMP_W'(col_ff);

   always_comb begin
      case (cmd.dir)
         DIR_UP: begin
            nbr_exists = (row_c != '0);
            nbr_addr   = here_ff - IDX_W'(GRID_SIDE);
         end
         DIR_DOWN: begin
            nbr_exists = (row_c < CMP_W'(GRID_SIDE - 1));
            nbr_addr   = here_ff + IDX_W'(GRID_SIDE);
         end
         DIR_LEFT: begin
            nbr_exists = (col_c != '0);
            nbr_addr   = here_ff - IDX_W'(1);
         end
         DIR_RIGHT: begin
            nbr_exists = (col_c < CMP_W'(GRID_SIDE - 1));
            nbr_addr   = here_ff + IDX_W'(1);
         end
         default: begin
            nbr_exists = 1'b0;
            nbr_addr   = here_ff;
         end
      endcase
   end

   // Relabel an entry that carries either label of the merge.
   assign wk_match = wk_pend_ff && ((rd_label == old_lab_ff) || (rd_label == new_lab_ff));

   // Select the memory write: clearing pass, open mark or relabel.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = here_ff;
      ram_wr_data = '0;
      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = {1'b0, (clr_addr_ff < IDX_W'(GRID_SIDE)), clr_addr_ff};
      end else if (cmd.open_here) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = here_ff;
         ram_wr_data = {1'b1, rd_full, rd_label};
      end else if (wk_match) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wk_wr_ff;
         ram_wr_data = {rd_open, rd_full | wet_ff, new_lab_ff};
      end
   end

   // Select the memory read address.
   always_comb begin
      if (cmd.rd_here) begin
         ram_rd_addr = here_ff;
      end else if (cmd.rd_nbr) begin
         ram_rd_addr = nbr_addr;
      end else begin
         ram_rd_addr = wk_rd_ff;
      end
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      in_range_in  = in_range_ff;
      here_in      = here_ff;
      new_lab_in   = new_lab_ff;
      old_lab_in   = old_lab_ff;
      here_full_in = here_full_ff;
      wet_in       = wet_ff;
      clr_addr_in  = clr_addr_ff;
      wk_rd_in     = wk_rd_ff;
      wk_run_in    = wk_run_ff;
      wk_pend_in   = wk_run_ff;
      wk_wr_in     = wk_rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_perc_in  = rsp_perc_ff;
      rsp_full_in  = rsp_full_ff;

      // Mark the grid percolating once a bottom-row site turns full.
      perc_in = perc_ff | (ram_wr_en && ram_wr_data[FULL_BIT] &&
                           (ram_wr_addr >= IDX_W'(BOTTOM_BASE)));

      if (cmd.clear) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
      end

      if (cmd.load) begin
         row_in      = req_row;
         col_in      = req_column;
         in_range_in = req_in_range;
         here_in     = here_wide[IDX_W-1:0];
      end

      if (cmd.open_here) begin
         new_lab_in   = rd_label;
         here_full_in = rd_full;
      end

      // Start the label walk when the neighbor is open.
      if (cmd.nbr_check && rd_open) begin
         old_lab_in   = rd_label;
         wet_in       = here_full_ff | rd_full;
         here_full_in = here_full_ff | rd_full;
         wk_rd_in     = '0;
         wk_run_in    = 1'b1;
      end else if (wk_run_ff) begin
         wk_rd_in = wk_rd_ff + IDX_W'(1);
         if (wk_rd_ff == IDX_W'(LAST_SITE)) begin
            wk_run_in = 1'b0;
         end
      end

      // Hold the result until it is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.give) begin
         rsp_valid_in = 1'b1;
         rsp_perc_in  = perc_ff;
         rsp_full_in  = in_range_ff & here_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         wk_run_ff    <= 1'b0;
         wk_pend_ff   <= 1'b0;
         perc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         wk_run_ff    <= wk_run_in;
         wk_pend_ff   <= wk_pend_in;
         perc_ff      <= perc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      in_range_ff  <= in_range_in;
      here_ff      <= here_in;
      new_lab_ff   <= new_lab_in;
      old_lab_ff   <= old_lab_in;
      here_full_ff <= here_full_in;
      wet_ff       <= wet_in;
      wk_rd_ff     <= wk_rd_in;
      wk_wr_ff     <= wk_wr_in;
      rsp_perc_ff  <= rsp_perc_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign status.clear_last = (clr_addr_ff == IDX_W'(LAST_SITE));
   assign status.in_range   = in_range_ff;
   assign status.nbr_exists = nbr_exists;
   assign status.nbr_open   = rd_open;
   assign status.walk_done  = wk_pend_ff && !wk_run_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_percolates = rsp_perc_ff;
   assign rsp_site_full  = rsp_full_ff;

endmodule

@@ rtl/grid_percolation_quick_find.sv @@
// Percolation engine for a GRID_SIDE x GRID_SIDE grid on a quick-find union-find.
// Each item opens the site at (row, column) and merges it with its open
// neighbors in the order up, down, left, right; each result tells whether the
// grid percolates (some bottom-row site is full) and whether the opened site is
// full. Sites outside the grid change nothing and report site_full as 0. Open
// flag, full flag and label of every site share one memory word, read and
// written once a cycle, so each merge is a walk over all GRID_SIDE^2 entries.
// After reset a clearing pass over all GRID_SIDE^2 entries initializes the
// memory, during which no item is accepted. A new item is accepted while the
// previous result still waits on the output.
module grid_percolation_quick_find #(
   parameter int GRID_SIDE = gpq_pkg::GRID_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gpq_pkg::COORD_W-1:0] req_row,
   input  logic [gpq_pkg::COORD_W-1:0] req_column,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_percolates,
   output logic                        rsp_site_full
);

   import gpq_pkg::*;

   localparam int SITE_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int IDX_W  = $clog2(SITE_COUNT);
   localparam int WORD_W = IDX_W + 2;

   gpq_cmd_type    cmd;
   gpq_status_type status;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   gpq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gpq_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_row        (req_row),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_percolates (rsp_percolates),
      .rsp_site_full  (rsp_site_full),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   gpq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SITE_COUNT)
   ) u_site_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

@@ rtl/gpq_checker.sv @@
`include "grid_percolation_quick_find_assert.svh"

module gpq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_percolates,
   input logic rsp_site_full
);

   logic       req_acc, rsp_acc;
   logic [1:0] pend_ff, pend_in;
   logic       seen_perc_ff, seen_perc_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Track items in flight and whether percolation was already reported.
   always_comb begin
      pend_in      = pend_ff + 2'(req_acc) - 2'(rsp_acc);
      seen_perc_in = seen_perc_ff | (rsp_acc && rsp_percolates);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         seen_perc_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         seen_perc_ff <= seen_perc_in;
      end
   end

   `GPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_percolates) && $stable(rsp_site_full))
   `GPQ_ASSERT_NOW(a_rsp_has_item, clock, reset, rsp_valid, pend_ff != 2'd0)
   `GPQ_ASSERT_NOW(a_in_flight_bound, clock, reset, req_acc, pend_ff <= 2'd1)
   `GPQ_ASSERT_NOW(a_perc_sticky, clock, reset, rsp_valid && seen_perc_ff, rsp_percolates)
   `GPQ_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready)

endmodule

bind grid_percolation_quick_find gpq_checker u_gpq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_percolates (rsp_percolates),
   .rsp_site_full  (rsp_site_full)
);

@@ sim/tb_grid_percolation_quick_find.sv @@
module tb_grid_percolation_quick_find;
   timeunit 1ns;
   timeprecision 1ps;

   import gpq_pkg::*;

   localparam int SIDE    = GRID_SIDE_DEF;
   localparam int SITES   = SIDE * SIDE;
   localparam int LABEL_W = $clog2(SITES);
   // Worst item: four full label walks, plus the clearing pass and both idle bursts.
   localparam int WATCHDOG_LIMIT = 6 * (4 * (SITES + 3) + 4 + SITES + 40);
   localparam int SETTLE_CYCLES  = 64;

   typedef struct packed {
      logic percolates;
      logic site_full;
   } percolation_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [COORD_W-1:0]  req_row = '0;
   logic [COORD_W-1:0]  req_column = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_percolates;
   logic                rsp_site_full;

   // Shadow copy of the grid state
   bit                  is_open  [SITES];
   bit                  is_wet   [SITES];
   logic [LABEL_W-1:0]  comp_label [SITES];

   percolation_result_type pending_results [$];
   int                  errors = 0;
   int                  idle_cycles = 0;
   int                  gap_pct = 0;
   int                  stall_pct = 0;
   int                  stall_left = 0;
   bit                  calm = 1'b0;

   grid_percolation_quick_find #(
      .GRID_SIDE(SIDE)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_row       (req_row),
      .req_column    (req_column),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_percolates(rsp_percolates),
      .rsp_site_full (rsp_site_full)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   // Merge the neighbor's component into the opened site's component.
   function automatic void join_sites(input int nbr, input int here);
      logic [LABEL_W-1:0] old_label;
      logic [LABEL_W-1:0] new_label;
      bit                 wet;
      old_label = comp_label[nbr];
      new_label = comp_label[here];
      wet = is_wet[nbr] || is_wet[here];
      for (int s = 0; s < SITES; s++) begin
         if (comp_label[s] == old_label || comp_label[s] == new_label) begin
            comp_label[s] = new_label;
            if (wet) is_wet[s] = 1'b1;
         end
      end
   endfunction

   // Open one site, merge with open neighbors, and report the grid.
   function automatic percolation_result_type open_site(input int row, input int column);
      percolation_result_type res;
      int                     here;
      res = '0;
      if (row < SIDE && column < SIDE) begin
         here = row * SIDE + column;
         is_open[here] = 1'b1;
         if (row > 0 && is_open[here - SIDE]) join_sites(here - SIDE, here);
         if (row + 1 < SIDE && is_open[here + SIDE]) join_sites(here + SIDE, here);
         if (column > 0 && is_open[here - 1]) join_sites(here - 1, here);
         if (column + 1 < SIDE && is_open[here + 1]) join_sites(here + 1, here);
         res.site_full = is_wet[here];
      end
      for (int c = 0; c < SIDE; c++) begin
         if (is_wet[(SIDE - 1) * SIDE + c]) res.percolates = 1'b1;
      end
      return res;
   endfunction

   // Drive one item, hold it until accepted, then record its expected result.
   task automatic send_site(input int row, input int column);
      percolation_result_type want;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_row    <= row[COORD_W-1:0];
      req_column <= column[COORD_W-1:0];
      do @(posedge clock); while (!req_ready);
      want = open_site(row, column);
      pending_results.push_back(want);
   endtask

   // Stall the result side in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(1, 19) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result with the oldest expectation.
   always @(posedge clock) begin
      percolation_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected (percolates %0b site_full %0b)",
                                      rsp_percolates, rsp_site_full));
         end else begin
            want = pending_results.pop_front();
            if (rsp_percolates !== want.percolates)
               report_mismatch($sformatf("percolates got %0b want %0b",
                                         rsp_percolates, want.percolates));
            if (rsp_site_full !== want.site_full)
               report_mismatch($sformatf("site_full got %0b want %0b",
                                         rsp_site_full, want.site_full));
         end
      end
   end

   // End the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Open the four corners, then reopen one of them.
   task automatic test_corners();
      gap_pct   = 30;
      stall_pct = 10;
      send_site(0, 0);
      send_site(SIDE - 1, SIDE - 1);
      send_site(0, SIDE - 1);
      send_site(SIDE - 1, 0);
      send_site(0, 0);
   endtask

   // Merges from each direction, including all four at once.
   task automatic test_merges();
      gap_pct   = 0;
      stall_pct = 0;
      send_site(0, 1);
      send_site(1, 0);
      send_site(1, 1);
      send_site(SIDE - 1, SIDE - 2);
      send_site(4, 5);
      send_site(6, 5);
      send_site(5, 4);
      send_site(5, 6);
      send_site(5, 5);
      send_site(5, 5);
   endtask

   // A closed top-row site is full but joins nothing until opened.
   task automatic test_closed_top();
      gap_pct   = 50;
      stall_pct = 30;
      send_site(1, 10);
      send_site(0, 10);
   endtask

   // Mostly downward walks from the top row, mixed with random sites.
   task automatic test_random_paths(input int count);
      int row;
      int column;
      int step;
      int move;
      row    = SIDE;
      column = 0;
      for (step = 0; step < count; step++) begin
         if (step % 25 == 0) begin
            gap_pct   = $urandom_range(0, 2) * 30;
            stall_pct = $urandom_range(0, 2) * 15;
         end
         if ($urandom_range(0, 99) < 25) begin
            send_site($urandom_range(0, (1 << COORD_W) - 1),
                      $urandom_range(0, (1 << COORD_W) - 1));
         end else begin
            if (row >= SIDE) begin
               row    = 0;
               column = $urandom_range(0, SIDE - 1);
            end
            send_site(row, column);
            // advance the walk; drop it at the bottom or now and then at random
            move = $urandom_range(0, 9);
            if (row == SIDE - 1 || $urandom_range(0, 99) < 2) row = SIDE;
            else if (move < 7) row++;
            else if (move < 8) column = (column > 0) ? column - 1 : column;
            else column = (column < SIDE - 1) ? column + 1 : column;
         end
      end
   endtask

   // Final stretch with no idling on either side.
   task automatic test_quiet_tail();
      calm = 1'b1;
      test_random_paths(20);
   endtask

   initial begin
      for (int s = 0; s < SITES; s++) begin
         is_open[s]    = 1'b0;
         is_wet[s]     = (s < SIDE);
         comp_label[s] = s[LABEL_W-1:0];
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_corners();
      test_merges();
      test_closed_top();
      test_random_paths(100);
      test_quiet_tail();

      // drain and let the block settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
